// ===== sv/blpg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator package
// Field widths, request and step codes, and the command word that passes
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package blpg_pkg;

    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int ADDR_W  = 16;
    localparam int COLOR_W = 8;
    localparam int ERR_W   = 10;
    localparam int STEP_W  = 2;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic [STEP_W-1:0] STEP_NONE = 2'b00;
    localparam logic [STEP_W-1:0] STEP_POS  = 2'b01;
    localparam logic [STEP_W-1:0] STEP_NEG  = 2'b11;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_START,
        CMD_RANGE,
        CMD_ADVANCE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [X_W-1:0]      x;
        logic [Y_W-1:0]      y;
        logic [ADDR_W-1:0]   addr;
        logic [X_W-1:0]      d_major;
        logic [X_W-1:0]      d_minor;
        logic [STEP_W-1:0]   step_x;
        logic [STEP_W-1:0]   step_y;
        logic                x_major;
        logic [COLOR_W-1:0]  color;
    } cmd_t;

endpackage
`default_nettype wire

// ===== sv/bresenham_line_pixel_generator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bresenham line pixel generator
// Top level: front end, command queue and back end of the line rasteriser.
// ----------------------------------------------------------------------------
// A start word checks both endpoints, sets up the line and returns its first
// pixel; each advance word returns the next pixel, with the address kept as
// row times WIDTH plus column and the final pixel flagged. Every accepted
// word gives exactly one result word, held first in the queue and then in
// the output register, and while the output is not stalled the block takes
// and returns one word per cycle without a gap. That rate is set by the back
// end, which updates the error term, the coordinates and the address of one
// pixel together for each command word; a two-word queue between front and
// back end keeps input and output stalls apart.
module bresenham_line_pixel_generator_core #(
    parameter int WIDTH  = 320,
    parameter int HEIGHT = 200
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          req_type,
    input  wire logic [blpg_pkg::X_W-1:0]      x_start,
    input  wire logic [blpg_pkg::Y_W-1:0]      y_start,
    input  wire logic [blpg_pkg::X_W-1:0]      x_end,
    input  wire logic [blpg_pkg::Y_W-1:0]      y_end,
    input  wire logic [blpg_pkg::COLOR_W-1:0]  pen_color,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               pixel_valid,
    output logic [blpg_pkg::X_W-1:0]           pixel_x,
    output logic [blpg_pkg::Y_W-1:0]           pixel_y,
    output logic [blpg_pkg::ADDR_W-1:0]        pixel_address,
    output logic [blpg_pkg::COLOR_W-1:0]       pixel_color,
    output logic                               line_done,
    output logic                               range_error
);

    blpg_pkg::cmd_t front_cmd;
    blpg_pkg::cmd_t back_cmd;
    logic           back_valid;
    logic           back_ready;

    blpg_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_front (
        .req_type  (req_type),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .pen_color (pen_color),
        .cmd       (front_cmd)
    );

    blpg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    blpg_back #(
        .WIDTH (WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (back_valid),
        .cmd_ready     (back_ready),
        .cmd           (back_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_valid   (pixel_valid),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .line_done     (line_done),
        .range_error   (range_error)
    );

`ifndef NO_ASSERTIONS
    // The incrementally tracked address must always match row times width plus column.
    a_address: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_valid |->
            pixel_address == 16'(32'(pixel_y) * 32'(WIDTH) + 32'(pixel_x)))
        else $error("pixel address does not match its coordinates");

    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_valid |->
            (32'(pixel_x) < 32'(WIDTH)) && (32'(pixel_y) < 32'(HEIGHT)))
        else $error("pixel emitted off screen");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> !pixel_valid && !line_done)
        else $error("range error word carries a pixel");

    a_done_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> pixel_valid)
        else $error("line end flagged without a pixel");
`endif

endmodule
`default_nettype wire

// ===== sv/blpg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Classifies each request word and, for a start, checks the endpoints and
// works out the deltas, step signs, major axis and start address.
// ----------------------------------------------------------------------------
module blpg_front #(
    parameter int WIDTH  = 320,
    parameter int HEIGHT = 200
) (
    input  wire logic                          req_type,
    input  wire logic [blpg_pkg::X_W-1:0]      x_start,
    input  wire logic [blpg_pkg::Y_W-1:0]      y_start,
    input  wire logic [blpg_pkg::X_W-1:0]      x_end,
    input  wire logic [blpg_pkg::Y_W-1:0]      y_end,
    input  wire logic [blpg_pkg::COLOR_W-1:0]  pen_color,
    output blpg_pkg::cmd_t                     cmd
);

    localparam logic [blpg_pkg::X_W-1:0]    W_X    = blpg_pkg::X_W'(WIDTH);
    localparam logic [blpg_pkg::Y_W-1:0]    H_Y    = blpg_pkg::Y_W'(HEIGHT);
    localparam logic [blpg_pkg::ADDR_W-1:0] W_ADDR = blpg_pkg::ADDR_W'(WIDTH);

    logic                       bad;
    logic [blpg_pkg::X_W-1:0]   abs_dx;
    logic [blpg_pkg::Y_W-1:0]   abs_dy;
    logic                       x_major;

    always_comb
    begin
        bad = (x_start >= W_X) || (x_end >= W_X) || (y_start >= H_Y) || (y_end >= H_Y);
        abs_dx = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
        abs_dy = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);
        x_major = abs_dx >= blpg_pkg::X_W'(abs_dy);

        cmd.x       = x_start;
        cmd.y       = y_start;
        cmd.addr    = blpg_pkg::ADDR_W'(y_start) * W_ADDR + blpg_pkg::ADDR_W'(x_start);
        cmd.d_major = x_major ? abs_dx : blpg_pkg::X_W'(abs_dy);
        cmd.d_minor = x_major ? blpg_pkg::X_W'(abs_dy) : abs_dx;
        cmd.step_x  = (x_end > x_start) ? blpg_pkg::STEP_POS :
                      ((x_end < x_start) ? blpg_pkg::STEP_NEG : blpg_pkg::STEP_NONE);
        cmd.step_y  = (y_end > y_start) ? blpg_pkg::STEP_POS :
                      ((y_end < y_start) ? blpg_pkg::STEP_NEG : blpg_pkg::STEP_NONE);
        cmd.x_major = x_major;
        cmd.color   = pen_color;

        unique case (req_type)
            blpg_pkg::REQ_START:   cmd.kind = bad ? blpg_pkg::CMD_RANGE : blpg_pkg::CMD_START;
            blpg_pkg::REQ_ADVANCE: cmd.kind = blpg_pkg::CMD_ADVANCE;
            default:               cmd.kind = blpg_pkg::CMD_ADVANCE;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/blpg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator command queue
// A short first-in first-out queue of command words that lets the front
// and back ends stall independently.
// ----------------------------------------------------------------------------
module blpg_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  blpg_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output blpg_pkg::cmd_t  pop_cmd
);

    blpg_pkg::cmd_t                 entry_reg [blpg_pkg::QDEPTH];
    logic [blpg_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [blpg_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [blpg_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           push, pop;

    localparam logic [blpg_pkg::QPTR_W-1:0] LAST = blpg_pkg::QPTR_W'(blpg_pkg::QDEPTH - 1);
    localparam logic [blpg_pkg::QCNT_W-1:0] FULL = blpg_pkg::QCNT_W'(blpg_pkg::QDEPTH);
    localparam logic [blpg_pkg::QPTR_W-1:0] PTR_ONE = blpg_pkg::QPTR_W'(1);
    localparam logic [blpg_pkg::QCNT_W-1:0] CNT_ONE = blpg_pkg::QCNT_W'(1);

    always_comb
    begin
        push_ready  = count_reg != FULL;
        pop_valid   = count_reg != '0;
        pop_cmd     = entry_reg[rd_ptr_reg];
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = push ? ((wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_ONE)
                           : wr_ptr_reg;
        rd_ptr_next = pop ? ((rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_ONE)
                          : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== sv/blpg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator back end
// Holds the line state, runs one command word per cycle unless stalled, and
// keeps the result word in the output register until it is taken.
// ----------------------------------------------------------------------------
module blpg_back #(
    parameter int WIDTH = 320
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  blpg_pkg::cmd_t                     cmd,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               pixel_valid,
    output logic [blpg_pkg::X_W-1:0]           pixel_x,
    output logic [blpg_pkg::Y_W-1:0]           pixel_y,
    output logic [blpg_pkg::ADDR_W-1:0]        pixel_address,
    output logic [blpg_pkg::COLOR_W-1:0]       pixel_color,
    output logic                               line_done,
    output logic                               range_error
);

    localparam logic [blpg_pkg::ADDR_W-1:0] W_ADDR = blpg_pkg::ADDR_W'(WIDTH);

    logic                               active_reg, active_next;
    logic [blpg_pkg::X_W-1:0]           x_reg, x_next;
    logic [blpg_pkg::Y_W-1:0]           y_reg, y_next;
    logic [blpg_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [blpg_pkg::ERR_W-1:0]         err_reg, err_next;
    logic [blpg_pkg::X_W-1:0]           steps_reg, steps_next;
    logic [blpg_pkg::X_W-1:0]           d_major_reg, d_major_next;
    logic [blpg_pkg::X_W-1:0]           d_minor_reg, d_minor_next;
    logic [blpg_pkg::STEP_W-1:0]        step_x_reg, step_x_next;
    logic [blpg_pkg::STEP_W-1:0]        step_y_reg, step_y_next;
    logic                               x_major_reg, x_major_next;
    logic [blpg_pkg::COLOR_W-1:0]       color_reg, color_next;

    logic                               out_valid_reg, out_valid_next;
    logic                               pv_reg, pv_next;
    logic [blpg_pkg::X_W-1:0]           px_reg, px_next;
    logic [blpg_pkg::Y_W-1:0]           py_reg, py_next;
    logic [blpg_pkg::ADDR_W-1:0]        pa_reg, pa_next;
    logic [blpg_pkg::COLOR_W-1:0]       pc_reg, pc_next;
    logic                               done_reg, done_next;
    logic                               rerr_reg, rerr_next;

    logic                               fire;
    logic [blpg_pkg::ERR_W-1:0]         e_sum;
    logic                               carry;
    logic                               move_x, move_y;
    logic [blpg_pkg::X_W-1:0]           dx;
    logic [blpg_pkg::Y_W-1:0]           dy;
    logic [blpg_pkg::ADDR_W-1:0]        da_x, da_y;

    always_comb
    begin
        cmd_ready = !out_valid_reg || out_ready;
        fire      = cmd_valid && cmd_ready;

        e_sum  = err_reg + blpg_pkg::ERR_W'(d_minor_reg);
        carry  = e_sum >= blpg_pkg::ERR_W'(d_major_reg);
        move_x = x_major_reg || carry;
        move_y = !x_major_reg || carry;

        case (step_x_reg)
            blpg_pkg::STEP_POS:
            begin
                dx   = blpg_pkg::X_W'(1);
                da_x = blpg_pkg::ADDR_W'(1);
            end
            blpg_pkg::STEP_NEG:
            begin
                dx   = '1;
                da_x = '1;
            end
            default:
            begin
                dx   = '0;
                da_x = '0;
            end
        endcase

        case (step_y_reg)
            blpg_pkg::STEP_POS:
            begin
                dy   = blpg_pkg::Y_W'(1);
                da_y = W_ADDR;
            end
            blpg_pkg::STEP_NEG:
            begin
                dy   = '1;
                da_y = '0 - W_ADDR;
            end
            default:
            begin
                dy   = '0;
                da_y = '0;
            end
        endcase

        active_next  = active_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        addr_next    = addr_reg;
        err_next     = err_reg;
        steps_next   = steps_reg;
        d_major_next = d_major_reg;
        d_minor_next = d_minor_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        x_major_next = x_major_reg;
        color_next   = color_reg;

        pv_next   = 1'b0;
        px_next   = '0;
        py_next   = '0;
        pa_next   = '0;
        pc_next   = '0;
        done_next = 1'b0;
        rerr_next = 1'b0;

        if (fire)
        begin
            unique case (cmd.kind)
                blpg_pkg::CMD_START:
                begin
                    x_next       = cmd.x;
                    y_next       = cmd.y;
                    addr_next    = cmd.addr;
                    err_next     = blpg_pkg::ERR_W'(cmd.d_major >> 1);
                    steps_next   = cmd.d_major;
                    d_major_next = cmd.d_major;
                    d_minor_next = cmd.d_minor;
                    step_x_next  = cmd.step_x;
                    step_y_next  = cmd.step_y;
                    x_major_next = cmd.x_major;
                    color_next   = cmd.color;
                    active_next  = cmd.d_major != '0;
                    pv_next      = 1'b1;
                    px_next      = cmd.x;
                    py_next      = cmd.y;
                    pa_next      = cmd.addr;
                    pc_next      = cmd.color;
                    done_next    = cmd.d_major == '0;
                end
                blpg_pkg::CMD_RANGE:
                begin
                    active_next = 1'b0;
                    rerr_next   = 1'b1;
                end
                blpg_pkg::CMD_ADVANCE:
                begin
                    if (active_reg)
                    begin
                        err_next   = carry ? (e_sum - blpg_pkg::ERR_W'(d_major_reg)) : e_sum;
                        x_next     = move_x ? (x_reg + dx) : x_reg;
                        y_next     = move_y ? (y_reg + dy) : y_reg;
                        addr_next  = addr_reg + (move_x ? da_x : '0) + (move_y ? da_y : '0);
                        steps_next = steps_reg - blpg_pkg::X_W'(1);
                        active_next = steps_next != '0;
                        pv_next    = 1'b1;
                        px_next    = x_next;
                        py_next    = y_next;
                        pa_next    = addr_next;
                        pc_next    = color_reg;
                        done_next  = steps_next == '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_valid_next = fire ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        addr_reg    <= addr_next;
        err_reg     <= err_next;
        steps_reg   <= steps_next;
        d_major_reg <= d_major_next;
        d_minor_reg <= d_minor_next;
        step_x_reg  <= step_x_next;
        step_y_reg  <= step_y_next;
        x_major_reg <= x_major_next;
        color_reg   <= color_next;
        if (fire)
        begin
            pv_reg   <= pv_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            pa_reg   <= pa_next;
            pc_reg   <= pc_next;
            done_reg <= done_next;
            rerr_reg <= rerr_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_valid   = pv_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign pixel_address = pa_reg;
    assign pixel_color   = pc_reg;
    assign line_done     = done_reg;
    assign range_error   = rerr_reg;

endmodule
`default_nettype wire

// ===== tb/tb_bresenham_line_pixel_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Bresenham line pixel generator core
// Drives start and advance words through the input handshake and checks
// every returned pixel word against a cycle-free model of the rasteriser.
// A short directed part is followed by random line sequences under three
// idling patterns.
// ----------------------------------------------------------------------------
class pixel_scoreboard #(int WIDTH = 320, int HEIGHT = 200);

    typedef struct packed {
        logic                               valid;
        logic [blpg_pkg::X_W-1:0]           x;
        logic [blpg_pkg::Y_W-1:0]           y;
        logic [blpg_pkg::ADDR_W-1:0]        addr;
        logic [blpg_pkg::COLOR_W-1:0]       color;
        logic                               done;
        logic                               range_err;
    } pixel_word_t;

    pixel_word_t pending_pixels[$];
    int mismatches;

    logic                               active;
    logic [blpg_pkg::X_W-1:0]           cur_x;
    logic [blpg_pkg::Y_W-1:0]           cur_y;
    logic [blpg_pkg::ERR_W-1:0]         err_acc;
    logic [blpg_pkg::X_W-1:0]           steps_left;
    logic [blpg_pkg::X_W-1:0]           abs_dx;
    logic [blpg_pkg::Y_W-1:0]           abs_dy;
    logic [blpg_pkg::STEP_W-1:0]        step_x;
    logic [blpg_pkg::STEP_W-1:0]        step_y;
    logic                               x_major;
    logic [blpg_pkg::COLOR_W-1:0]       line_color;

    function new();
        mismatches = 0;
        active = 1'b0;
        cur_x = '0;
        cur_y = '0;
        err_acc = '0;
        steps_left = '0;
        abs_dx = '0;
        abs_dy = '0;
        step_x = blpg_pkg::STEP_NONE;
        step_y = blpg_pkg::STEP_NONE;
        x_major = 1'b0;
        line_color = '0;
    endfunction

    function logic [blpg_pkg::X_W-1:0] take_step(logic [blpg_pkg::X_W-1:0] v,
                                                 logic [blpg_pkg::STEP_W-1:0] s);
        case (s)
            blpg_pkg::STEP_POS: return v + blpg_pkg::X_W'(1);
            blpg_pkg::STEP_NEG: return v - blpg_pkg::X_W'(1);
            default:            return v;
        endcase
    endfunction

    function pixel_word_t current_pixel();
        pixel_word_t p;
        p.valid = 1'b1;
        p.x = cur_x;
        p.y = cur_y;
        p.addr = blpg_pkg::ADDR_W'(int'(cur_y) * WIDTH + int'(cur_x));
        p.color = line_color;
        p.done = (steps_left == '0);
        p.range_err = 1'b0;
        return p;
    endfunction

    function void note_request(logic req, logic [blpg_pkg::X_W-1:0] xs,
                               logic [blpg_pkg::Y_W-1:0] ys,
                               logic [blpg_pkg::X_W-1:0] xe,
                               logic [blpg_pkg::Y_W-1:0] ye,
                               logic [blpg_pkg::COLOR_W-1:0] col);
        pixel_word_t p;
        logic [blpg_pkg::X_W-1:0] major;
        p = '0;
        if (req == blpg_pkg::REQ_START)
        begin
            if (xs >= WIDTH || xe >= WIDTH || ys >= HEIGHT || ye >= HEIGHT)
            begin
                active = 1'b0;
                p.range_err = 1'b1;
            end
            else
            begin
                abs_dx = (xe >= xs) ? xe - xs : xs - xe;
                abs_dy = (ye >= ys) ? ye - ys : ys - ye;
                step_x = (xe > xs) ? blpg_pkg::STEP_POS :
                         ((xe < xs) ? blpg_pkg::STEP_NEG : blpg_pkg::STEP_NONE);
                step_y = (ye > ys) ? blpg_pkg::STEP_POS :
                         ((ye < ys) ? blpg_pkg::STEP_NEG : blpg_pkg::STEP_NONE);
                x_major = (abs_dx >= blpg_pkg::X_W'(abs_dy));
                major = x_major ? abs_dx : blpg_pkg::X_W'(abs_dy);
                err_acc = blpg_pkg::ERR_W'(major >> 1);
                steps_left = major;
                cur_x = xs;
                cur_y = ys;
                line_color = col;
                active = (steps_left != '0);
                p = current_pixel();
            end
        end
        else if (active)
        begin
            if (x_major)
            begin
                err_acc = err_acc + blpg_pkg::ERR_W'(abs_dy);
                if (err_acc >= blpg_pkg::ERR_W'(abs_dx))
                begin
                    err_acc = err_acc - blpg_pkg::ERR_W'(abs_dx);
                    cur_y = blpg_pkg::Y_W'(take_step(blpg_pkg::X_W'(cur_y), step_y));
                end
                cur_x = take_step(cur_x, step_x);
            end
            else
            begin
                err_acc = err_acc + blpg_pkg::ERR_W'(abs_dx);
                if (err_acc >= blpg_pkg::ERR_W'(abs_dy))
                begin
                    err_acc = err_acc - blpg_pkg::ERR_W'(abs_dy);
                    cur_x = take_step(cur_x, step_x);
                end
                cur_y = blpg_pkg::Y_W'(take_step(blpg_pkg::X_W'(cur_y), step_y));
            end
            steps_left = steps_left - blpg_pkg::X_W'(1);
            if (steps_left == '0)
            begin
                active = 1'b0;
            end
            p = current_pixel();
        end
        pending_pixels.push_back(p);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_pixel(pixel_word_t got);
        pixel_word_t want;
        if (pending_pixels.size() == 0)
        begin
            $error("pixel word returned with none outstanding");
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("pixel_valid", 32'(want.valid), 32'(got.valid));
        compare_field("pixel_x", 32'(want.x), 32'(got.x));
        compare_field("pixel_y", 32'(want.y), 32'(got.y));
        compare_field("pixel_address", 32'(want.addr), 32'(got.addr));
        compare_field("pixel_color", 32'(want.color), 32'(got.color));
        compare_field("line_done", 32'(want.done), 32'(got.done));
        compare_field("range_error", 32'(want.range_err), 32'(got.range_err));
    endfunction

endclass

module tb_bresenham_line_pixel_generator_core;

    localparam int SCREEN_W = 320;
    localparam int SCREEN_H = 200;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               req_type;
    logic [blpg_pkg::X_W-1:0]           x_start;
    logic [blpg_pkg::Y_W-1:0]           y_start;
    logic [blpg_pkg::X_W-1:0]           x_end;
    logic [blpg_pkg::Y_W-1:0]           y_end;
    logic [blpg_pkg::COLOR_W-1:0]       pen_color;
    logic                               out_valid;
    logic                               out_ready;
    logic                               pixel_valid;
    logic [blpg_pkg::X_W-1:0]           pixel_x;
    logic [blpg_pkg::Y_W-1:0]           pixel_y;
    logic [blpg_pkg::ADDR_W-1:0]        pixel_address;
    logic [blpg_pkg::COLOR_W-1:0]       pixel_color;
    logic                               line_done;
    logic                               range_error;

    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;

    pixel_scoreboard #(SCREEN_W, SCREEN_H) sb;

    bresenham_line_pixel_generator_core #(
        .WIDTH  (SCREEN_W),
        .HEIGHT (SCREEN_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .x_start       (x_start),
        .y_start       (y_start),
        .x_end         (x_end),
        .y_end         (y_end),
        .pen_color     (pen_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_valid   (pixel_valid),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .line_done     (line_done),
        .range_error   (range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_bresenham_line_pixel_generator_core failed");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_pixel({pixel_valid, pixel_x, pixel_y, pixel_address, pixel_color,
                            line_done, range_error});
        end
    end

    task automatic send_word(input logic req, input logic [blpg_pkg::X_W-1:0] xs,
                             input logic [blpg_pkg::Y_W-1:0] ys,
                             input logic [blpg_pkg::X_W-1:0] xe,
                             input logic [blpg_pkg::Y_W-1:0] ye,
                             input logic [blpg_pkg::COLOR_W-1:0] col);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        x_start   <= xs;
        y_start   <= ys;
        x_end     <= xe;
        y_end     <= ye;
        pen_color <= col;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(req, xs, ys, xe, ye, col);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_advance();
        send_word(blpg_pkg::REQ_ADVANCE,
                  blpg_pkg::X_W'($urandom_range(511)), blpg_pkg::Y_W'($urandom_range(255)),
                  blpg_pkg::X_W'($urandom_range(511)), blpg_pkg::Y_W'($urandom_range(255)),
                  blpg_pkg::COLOR_W'($urandom_range(255)));
    endtask

    task automatic send_advances(input int count);
        repeat (count)
        begin
            send_advance();
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // One random sequence: mostly a well-formed line followed by its advances,
    // sometimes cut short or overrun, with off-screen starts and stray advances
    // as noise.
    task automatic random_sequence();
        int kind;
        int xs;
        int ys;
        int xe;
        int ye;
        int n;
        int adv;
        logic [blpg_pkg::X_W-1:0] bxs;
        logic [blpg_pkg::Y_W-1:0] bys;
        logic [blpg_pkg::X_W-1:0] bxe;
        logic [blpg_pkg::Y_W-1:0] bye;
        kind = int'($urandom_range(99));
        if (kind < 8)
        begin
            bxs = blpg_pkg::X_W'($urandom_range(511));
            bys = blpg_pkg::Y_W'($urandom_range(255));
            bxe = blpg_pkg::X_W'($urandom_range(511));
            bye = blpg_pkg::Y_W'($urandom_range(255));
            case ($urandom_range(3))
                0:       bxs = blpg_pkg::X_W'($urandom_range(511, SCREEN_W));
                1:       bxe = blpg_pkg::X_W'($urandom_range(511, SCREEN_W));
                2:       bys = blpg_pkg::Y_W'($urandom_range(255, SCREEN_H));
                default: bye = blpg_pkg::Y_W'($urandom_range(255, SCREEN_H));
            endcase
            send_word(blpg_pkg::REQ_START, bxs, bys, bxe, bye,
                      blpg_pkg::COLOR_W'($urandom_range(255)));
            send_advances(int'($urandom_range(2)));
        end
        else if (kind < 14)
        begin
            send_advance();
        end
        else
        begin
            xs = int'($urandom_range(SCREEN_W - 1));
            ys = int'($urandom_range(SCREEN_H - 1));
            if ($urandom_range(19) == 0)
            begin
                xe = int'($urandom_range(SCREEN_W - 1));
                ye = int'($urandom_range(SCREEN_H - 1));
            end
            else
            begin
                xe = xs + int'($urandom_range(24)) - 12;
                ye = ys + int'($urandom_range(24)) - 12;
                if (xe < 0) xe = 0;
                if (xe > SCREEN_W - 1) xe = SCREEN_W - 1;
                if (ye < 0) ye = 0;
                if (ye > SCREEN_H - 1) ye = SCREEN_H - 1;
            end
            n = (xe > xs) ? xe - xs : xs - xe;
            if (((ye > ys) ? ye - ys : ys - ye) > n)
            begin
                n = (ye > ys) ? ye - ys : ys - ye;
            end
            kind = int'($urandom_range(9));
            if (kind == 0)
                adv = n + 1;
            else if (kind == 1 && n > 0)
                adv = int'($urandom_range(n - 1));
            else
                adv = n;
            send_word(blpg_pkg::REQ_START, blpg_pkg::X_W'(xs), blpg_pkg::Y_W'(ys),
                      blpg_pkg::X_W'(xe), blpg_pkg::Y_W'(ye),
                      blpg_pkg::COLOR_W'($urandom_range(255)));
            send_advances(adv);
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int count);
        int goal;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        goal = words_sent + count;
        while (words_sent < goal)
        begin
            random_sequence();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = blpg_pkg::REQ_START;
        x_start = '0;
        y_start = '0;
        x_end = '0;
        y_end = '0;
        pen_color = '0;
        send_idle_pct = 36;
        recv_idle_pct = 50;
        words_sent = 0;
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_advance();
        send_word(blpg_pkg::REQ_START, 9'd0, 8'd0, 9'd0, 8'd0, 8'd0);
        send_advance();
        send_word(blpg_pkg::REQ_START, 9'd319, 8'd199, 9'd319, 8'd199, 8'd255);
        send_word(blpg_pkg::REQ_START, 9'd0, 8'd0, 9'd319, 8'd199, 8'hA5);
        send_advances(2);
        // Start while busy: the full-screen diagonal is abandoned.
        send_word(blpg_pkg::REQ_START, 9'd319, 8'd0, 9'd0, 8'd199, 8'h5A);
        send_advances(1);
        send_word(blpg_pkg::REQ_START, 9'd10, 8'd10, 9'd14, 8'd10, 8'h11);
        send_advances(4);
        send_word(blpg_pkg::REQ_START, 9'd50, 8'd60, 9'd50, 8'd58, 8'h22);
        send_advances(2);
        send_word(blpg_pkg::REQ_START, 9'd20, 8'd30, 9'd18, 8'd34, 8'h33);
        send_advances(2);
        // An off-screen start cancels the steep line still in progress.
        send_word(blpg_pkg::REQ_START, 9'd320, 8'd100, 9'd100, 8'd100, 8'h44);
        send_advance();
        send_word(blpg_pkg::REQ_START, 9'd0, 8'd0, 9'd511, 8'd0, 8'h55);
        send_word(blpg_pkg::REQ_START, 9'd0, 8'd200, 9'd0, 8'd0, 8'h66);
        send_word(blpg_pkg::REQ_START, 9'd0, 8'd0, 9'd0, 8'd255, 8'h77);
        wait_drained();

        run_phase(36, 50, 240);
        run_phase(50, 36, 240);
        run_phase(0, 0, 240);

        repeat (10) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("tb_bresenham_line_pixel_generator_core passed");
        else
            $display("tb_bresenham_line_pixel_generator_core failed");
        $finish;
    end

endmodule
